// ===== design/rssm_pkg.sv =====
package rssm_pkg;
  localparam int Capacity = 1024;
  localparam int AddrW = $clog2(Capacity);
  localparam int CntW = AddrW + 1;
  localparam int CpW = 21;
  localparam int KeyW = 2 * CpW;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_COMPACT = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SCAN_RD,
    S_SCAN,
    S_SWAP,
    S_SWAP2,
    S_MRG_RD,
    S_MRG,
    S_MRG_WB,
    S_ADD_CHK,
    S_RESULT
  } state_t;
endpackage

// ===== design/range_set_sort_merge_unit.sv =====
// Each result waits in the output register until taken; the next transaction is
//   accepted in the cycle after the result is taken.
// A compaction (explicit, or before an add to a table one entry short of full)
//   bubble-sorts the table in memory, then merges overlapping and adjacent ranges.
// Reset clears the entry count and control state; the range stores are not cleared.
module range_set_sort_merge_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic [20:0]             range_low,
  input  logic [20:0]             range_high,
  input  logic [9:0]              entry_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [20:0]             out_low,
  output logic [20:0]             out_high,
  output logic [10:0]             entry_total,
  output logic [1:0]              status
);
  localparam int AW = rssm_pkg::AddrW;
  localparam int CW = rssm_pkg::CntW;
  localparam int PW = rssm_pkg::CpW;

  logic [PW-1:0] lo_mem [rssm_pkg::Capacity];
  logic [PW-1:0] hi_mem [rssm_pkg::Capacity];

  rssm_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    op_r, op_r_next;
  logic [PW-1:0] a_lo, a_lo_next, a_hi, a_hi_next;
  logic [9:0]    idx_r, idx_r_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] wr_m, wr_m_next;
  logic          swapped, swapped_next;
  logic          have, have_next;
  logic [PW-1:0] cur_lo, cur_lo_next, cur_hi, cur_hi_next;
  logic [PW-1:0] p_lo, p_lo_next, p_hi, p_hi_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] wlo, whi;
  logic [PW-1:0] rd_lo, rd_hi;

  logic          ov, ov_next;
  logic [PW-1:0] o_lo, o_lo_next, o_hi, o_hi_next;
  logic [1:0]    o_st, o_st_next;

  always_ff @(posedge clk) begin
    if (we) begin
      lo_mem[waddr] <= wlo;
      hi_mem[waddr] <= whi;
    end
    rd_lo <= lo_mem[raddr];
    rd_hi <= hi_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rssm_pkg::S_IDLE;
      count <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ov    <= ov_next;
    end
    op_r    <= op_r_next;
    a_lo    <= a_lo_next;
    a_hi    <= a_hi_next;
    idx_r   <= idx_r_next;
    ptr     <= ptr_next;
    wr_m    <= wr_m_next;
    swapped <= swapped_next;
    have    <= have_next;
    cur_lo  <= cur_lo_next;
    cur_hi  <= cur_hi_next;
    p_lo    <= p_lo_next;
    p_hi    <= p_hi_next;
    o_lo    <= o_lo_next;
    o_hi    <= o_hi_next;
    o_st    <= o_st_next;
  end

  logic [CW-1:0] full_lvl;
  logic [CW-1:0] ptr_ext;
  assign full_lvl = CW'(rssm_pkg::Capacity - 1);
  assign ptr_ext  = {1'b0, ptr};

  always_comb begin
    state_next   = state;
    count_next   = count;
    op_r_next    = op_r;
    a_lo_next    = a_lo;
    a_hi_next    = a_hi;
    idx_r_next   = idx_r;
    ptr_next     = ptr;
    wr_m_next    = wr_m;
    swapped_next = swapped;
    have_next    = have;
    cur_lo_next  = cur_lo;
    cur_hi_next  = cur_hi;
    p_lo_next    = p_lo;
    p_hi_next    = p_hi;
    o_lo_next    = o_lo;
    o_hi_next    = o_hi;
    o_st_next    = o_st;
    ov_next      = ov && out_stall;
    we           = 1'b0;
    waddr        = ptr;
    wlo          = a_lo;
    whi          = a_hi;
    raddr        = ptr;
    in_stall     = 1'b1;

    case (state)
      rssm_pkg::S_IDLE: begin
        in_stall = ov;
        if (in_valid && !ov) begin
          op_r_next  = op;
          a_lo_next  = range_low;
          a_hi_next  = range_high;
          idx_r_next = entry_index;
          ptr_next   = '0;
          case (rssm_pkg::op_t'(op))
            rssm_pkg::OP_CLEAR: begin
              count_next = '0;
              o_st_next  = rssm_pkg::ST_OK;
              state_next = rssm_pkg::S_RESULT;
            end
            rssm_pkg::OP_READ: begin
              raddr      = entry_index[AW-1:0];
              state_next = rssm_pkg::S_READ;
            end
            default: begin
              if (op == rssm_pkg::OP_COMPACT || count >= full_lvl) begin
                swapped_next = 1'b0;
                state_next   = (count > CW'(1)) ? rssm_pkg::S_SCAN_RD
                                                : rssm_pkg::S_MRG_RD;
              end else begin
                state_next = rssm_pkg::S_ADD_CHK;
              end
            end
          endcase
        end
      end

      rssm_pkg::S_READ: begin
        if ({1'b0, idx_r} < count) begin
          o_lo_next = rd_lo;
          o_hi_next = rd_hi;
          o_st_next = rssm_pkg::ST_OK;
        end else begin
          o_st_next = rssm_pkg::ST_RANGE;
        end
        state_next = rssm_pkg::S_RESULT;
      end

      // bubble pass: hold entry ptr in p, compare with ptr+1
      rssm_pkg::S_SCAN_RD: begin
        raddr      = ptr;
        state_next = rssm_pkg::S_SCAN;
        have_next  = 1'b0;
      end

      rssm_pkg::S_SCAN: begin
        if (!have) begin
          p_lo_next = rd_lo;
          p_hi_next = rd_hi;
          have_next = 1'b1;
          raddr     = ptr + AW'(1);
        end else begin
          raddr = ptr + AW'(1);
          if ({rd_lo, rd_hi} < {p_lo, p_hi}) begin
            cur_lo_next = rd_lo;
            cur_hi_next = rd_hi;
            state_next  = rssm_pkg::S_SWAP;
          end else begin
            p_lo_next = rd_lo;
            p_hi_next = rd_hi;
            if (ptr_ext + CW'(2) >= count) begin
              state_next = swapped ? rssm_pkg::S_SCAN_RD : rssm_pkg::S_MRG_RD;
              ptr_next   = '0;
              swapped_next = 1'b0;
            end else begin
              ptr_next = ptr + AW'(1);
              raddr    = ptr + AW'(2);
              // hold read for next compare; data arrives next cycle
              state_next = rssm_pkg::S_SCAN;
            end
          end
        end
      end

      rssm_pkg::S_SWAP: begin
        we    = 1'b1;
        waddr = ptr;
        wlo   = cur_lo;
        whi   = cur_hi;
        state_next = rssm_pkg::S_SWAP2;
      end

      rssm_pkg::S_SWAP2: begin
        we    = 1'b1;
        waddr = ptr + AW'(1);
        wlo   = p_lo;
        whi   = p_hi;
        swapped_next = 1'b1;
        raddr = ptr + AW'(2);
        if (ptr_ext + CW'(2) >= count) begin
          ptr_next   = '0;
          state_next = rssm_pkg::S_SCAN_RD;
          swapped_next = 1'b0;
        end else begin
          ptr_next   = ptr + AW'(1);
          state_next = rssm_pkg::S_SCAN;
        end
      end

      rssm_pkg::S_MRG_RD: begin
        raddr      = '0;
        ptr_next   = '0;
        wr_m_next  = '0;
        have_next  = 1'b0;
        state_next = (count == '0) ? rssm_pkg::S_ADD_CHK : rssm_pkg::S_MRG;
      end

      rssm_pkg::S_MRG: begin
        state_next = rssm_pkg::S_MRG_WB;
        if (rd_lo <= rd_hi) begin
          if (have && ({1'b0, rd_lo} <= {1'b0, cur_hi} + (PW+1)'(1))) begin
            if (rd_hi > cur_hi) cur_hi_next = rd_hi;
          end else begin
            if (have) begin
              we    = 1'b1;
              waddr = wr_m[AW-1:0];
              wlo   = cur_lo;
              whi   = cur_hi;
              wr_m_next = wr_m + CW'(1);
            end
            cur_lo_next = rd_lo;
            cur_hi_next = rd_hi;
            have_next   = 1'b1;
          end
        end
      end

      rssm_pkg::S_MRG_WB: begin
        if (ptr_ext + CW'(1) >= count) begin
          if (have) begin
            we    = 1'b1;
            waddr = wr_m[AW-1:0];
            wlo   = cur_lo;
            whi   = cur_hi;
            count_next = wr_m + CW'(1);
          end else begin
            count_next = wr_m;
          end
          state_next = rssm_pkg::S_ADD_CHK;
        end else begin
          ptr_next   = ptr + AW'(1);
          raddr      = ptr + AW'(1);
          state_next = rssm_pkg::S_MRG;
        end
      end

      rssm_pkg::S_ADD_CHK: begin
        o_st_next  = rssm_pkg::ST_OK;
        state_next = rssm_pkg::S_RESULT;
        if (op_r == rssm_pkg::OP_ADD) begin
          if (count >= full_lvl) begin
            o_st_next = rssm_pkg::ST_OVERFLOW;
          end else begin
            we    = 1'b1;
            waddr = count[AW-1:0];
            if (a_hi != '0 && a_lo > a_hi) begin
              wlo = a_hi;
              whi = a_lo;
            end else begin
              wlo = a_lo;
              whi = a_hi;
            end
            count_next = count + CW'(1);
          end
        end
      end

      rssm_pkg::S_RESULT: begin
        if (op_r != rssm_pkg::OP_READ || o_st_next != rssm_pkg::ST_OK) begin
          if (op_r != rssm_pkg::OP_READ) begin
            o_lo_next = '0;
            o_hi_next = '0;
          end
        end
        if (op_r == rssm_pkg::OP_READ && o_st == rssm_pkg::ST_RANGE) begin
          o_lo_next = '0;
          o_hi_next = '0;
        end
        ov_next    = 1'b1;
        state_next = rssm_pkg::S_IDLE;
      end

      default: state_next = rssm_pkg::S_IDLE;
    endcase
  end

  logic [CW-1:0] tot;
  always_ff @(posedge clk) begin
    if (state == rssm_pkg::S_RESULT) tot <= count;
  end

  assign out_valid   = ov;
  assign out_low     = o_lo;
  assign out_high    = o_hi;
  assign entry_total = tot;
  assign status      = o_st;
endmodule
